// ----- sv/i2a_pkg.sv -----
package i2a_pkg;

  // Word size and derived digit counts
  localparam int WORD_BITS  = 32;
  localparam int DEC_DIGITS = (WORD_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
  localparam int NDIG       = DEC_DIGITS;
  localparam int DIG_W      = NDIG * 4;
  localparam int HEX_W      = HEX_DIGITS * 4;
  localparam int CNT_W      = $clog2(WORD_BITS + 1);
  localparam int REM_W      = $clog2(NDIG + 1);

  // Port field widths
  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 7;

  // Conversion modes; the unused code behaves as unsigned decimal
  localparam logic [OP_W-1:0] OP_SIGNED   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNSIGNED = 2'd1;
  localparam logic [OP_W-1:0] OP_HEX      = 2'd2;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic dig_shift;
    logic show_sign;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic top_zero;
    logic rem_one;
    logic negative;
  } status_t;

endpackage

// ----- sv/i2a_datapath.sv -----
module i2a_datapath (
  input  logic                                  clk,
  input  logic [i2a_pkg::VALUE_W-1:0]           in_value,
  input  logic [i2a_pkg::OP_W-1:0]              in_op,
  input  i2a_pkg::cmd_t                         cmd,
  output i2a_pkg::status_t                      status,
  output logic [i2a_pkg::CHAR_W-1:0]            character,
  output logic                                  last
);

  logic [i2a_pkg::WORD_BITS-1:0] bin_r, bin_nxt;
  logic [i2a_pkg::DIG_W-1:0]     dig_r, dig_nxt;
  logic [i2a_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [i2a_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;

  logic [i2a_pkg::WORD_BITS-1:0] word;
  logic [i2a_pkg::WORD_BITS-1:0] mag;
  logic [i2a_pkg::HEX_W-1:0]     hexw;
  logic                          neg_in;
  logic [i2a_pkg::DIG_W-1:0]     adj;
  logic [3:0]                    top;

  // Sign handling at load
  assign word   = i2a_pkg::WORD_BITS'(in_value);
  assign neg_in = (in_op == i2a_pkg::OP_SIGNED) && word[i2a_pkg::WORD_BITS-1];
  assign mag    = neg_in ? (~word + 1'b1) : word;
  assign hexw   = i2a_pkg::HEX_W'(mag);

  // Add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < i2a_pkg::NDIG; i++) begin
      if (dig_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = dig_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = dig_r[i*4 +: 4];
      end
    end
  end

  // Next-state of the datapath registers
  always_comb begin
    bin_nxt = bin_r;
    dig_nxt = dig_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      neg_nxt = neg_in;
      bin_nxt = mag;
      if (in_op == i2a_pkg::OP_HEX) begin
        // hex digits are the nibbles, top-aligned
        dig_nxt = i2a_pkg::DIG_W'(hexw) << (i2a_pkg::DIG_W - i2a_pkg::HEX_W);
        cnt_nxt = '0;
        rem_nxt = i2a_pkg::REM_W'(i2a_pkg::HEX_DIGITS);
      end else begin
        dig_nxt = '0;
        cnt_nxt = i2a_pkg::CNT_W'(i2a_pkg::WORD_BITS);
        rem_nxt = i2a_pkg::REM_W'(i2a_pkg::DEC_DIGITS);
      end
    end else if (cmd.conv_step) begin
      dig_nxt = {adj[i2a_pkg::DIG_W-2:0], bin_r[i2a_pkg::WORD_BITS-1]};
      bin_nxt = bin_r << 1;
      cnt_nxt = cnt_r - 1'b1;
    end else if (cmd.dig_shift) begin
      dig_nxt = dig_r << 4;
      rem_nxt = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    dig_r <= dig_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  // Status back to the controller
  assign top             = dig_r[i2a_pkg::DIG_W-1 -: 4];
  assign status.cnt_zero = (cnt_r == '0);
  assign status.top_zero = (top == 4'd0);
  assign status.rem_one  = (rem_r == i2a_pkg::REM_W'(1));
  assign status.negative = neg_r;

  // Character for the top digit, or the minus sign
  always_comb begin
    if (cmd.show_sign) begin
      character = i2a_pkg::CHAR_MINUS;
    end else if (top < 4'd10) begin
      character = i2a_pkg::CHAR_ZERO + i2a_pkg::CHAR_W'(top);
    end else begin
      character = i2a_pkg::CHAR_A + i2a_pkg::CHAR_W'(top) - 7'd10;
    end
  end

  assign last = !cmd.show_sign && status.rem_one;

endmodule

// ----- sv/i2a_ctrl.sv -----
module i2a_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  i2a_pkg::status_t status,
  output i2a_pkg::cmd_t    cmd
);

  i2a_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2a_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2a_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = i2a_pkg::ST_CONV;
      end
      i2a_pkg::ST_CONV: begin
        if (status.cnt_zero) state_nxt = i2a_pkg::ST_SKIP;
      end
      i2a_pkg::ST_SKIP: begin
        if (!status.top_zero || status.rem_one) begin
          state_nxt = status.negative ? i2a_pkg::ST_SIGN : i2a_pkg::ST_DIGIT;
        end
      end
      i2a_pkg::ST_SIGN: begin
        if (out_tready) state_nxt = i2a_pkg::ST_DIGIT;
      end
      i2a_pkg::ST_DIGIT: begin
        if (out_tready && status.rem_one) state_nxt = i2a_pkg::ST_IDLE;
      end
      default: state_nxt = i2a_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    cmd           = '0;
    case (state_r)
      i2a_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      i2a_pkg::ST_CONV: begin
        cmd.conv_step = !status.cnt_zero;
      end
      i2a_pkg::ST_SKIP: begin
        // drop leading zero digits, keep at least one
        cmd.dig_shift = status.top_zero && !status.rem_one;
      end
      i2a_pkg::ST_SIGN: begin
        out_tvalid    = 1'b1;
        cmd.show_sign = 1'b1;
      end
      i2a_pkg::ST_DIGIT: begin
        out_tvalid    = 1'b1;
        cmd.dig_shift = out_tready && !status.rem_one;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/integer_to_ascii.sv -----
// Sequence: accept, then conversion (hex: a count check only; decimal: 32 shift-add-3 steps,
// one per input bit, and a final count check), then leading-zero removal, then
// one character per cycle while out_tready is high.
// Throughput: one word at a time; a new word is not taken until the last character
// of the previous word is sent, set by the serial BCD shifter and character output.
// Reset: synchronous active-low rst_n returns the controller to idle.
module integer_to_ascii (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] value
  input  logic [1:0]                  in_tuser,   // [1:0] operation
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [6:0] character, [7] zero
  output logic                        out_tlast
);

  i2a_pkg::cmd_t                 cmd;
  i2a_pkg::status_t              status;
  logic [i2a_pkg::CHAR_W-1:0]    character;

  i2a_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  i2a_datapath u_dp (
    .clk       (clk),
    .in_value  (in_tdata),
    .in_op     (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (out_tlast)
  );

  assign out_tdata = {1'b0, character};

endmodule

// ----- sv/i2a_checker.sv -----
module i2a_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // No new word is taken while characters are being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while output busy");

  // A new word always needs conversion time before its first character
  a_conv_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("character right after input transaction");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[i2a_pkg::CHAR_W-1:0] == i2a_pkg::CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign flagged last");

  // Only 7-bit ASCII is emitted
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7] == 1'b0))
    else $error("non-ASCII character");

endmodule

bind integer_to_ascii i2a_checker u_i2a_checker (.*);
